// ===== rtl/core/cdod_pkg.sv =====
package cdod_pkg;

  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int OFS_W  = 23;
  localparam int NUM_W  = 22;
  localparam int STEP_W = 4;

  localparam int MAX_YEAR    = 9999;
  localparam int MONTHS      = 12;
  localparam int DAYS_400Y   = 146097;
  localparam int DAYS_100Y   = 36524;
  localparam int DAYS_4Y     = 1461;
  localparam int DAYS_1Y     = 365;
  localparam int LAST_DAYNUM = 3652058;
  localparam int DIV_STEPS   = 14;

  // floor(p / 100) == (p * RECIP100) >> RECIP100_SH for every year below 10000.
  localparam int RECIP100    = 5243;
  localparam int RECIP100_SH = 19;
  // Multiplicative inverse of 25 modulo 2**14, used for an exact divisibility test.
  localparam int INV25       = 7209;
  localparam int INV25_LIM   = 655;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEAP,
    ST_MUL,
    ST_ADD,
    ST_NUM,
    ST_CLAMP,
    ST_DIV,
    ST_RLEAP,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              load;
    logic              leap;
    logic              mul;
    logic              add;
    logic              num;
    logic              clamp;
    logic              div;
    logic              rleap;
    logic              walk;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic walk_done;
  } stat_t;

  typedef struct packed {
    logic [NUM_W-1:0]  divisor;
    logic [YEAR_W-1:0] weight;
  } div_step_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic                div4;
    logic                div16;
    logic                div25;
    prod  = (2*YEAR_W)'(y) * (2*YEAR_W)'(INV25);
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    div25 = (prod[YEAR_W-1:0] <= YEAR_W'(INV25_LIM));
    return (div4 && !div25) || (div16 && div25);
  endfunction

  function automatic logic [YEAR_W-1:0] sat_year(input logic [YEAR_W-1:0] y);
    if (y == '0) begin
      return YEAR_W'(1);
    end else if (y > YEAR_W'(MAX_YEAR)) begin
      return YEAR_W'(MAX_YEAR);
    end
    return y;
  endfunction

  function automatic logic [MON_W-1:0] sat_month(input logic [MON_W-1:0] m);
    if (m == '0) begin
      return MON_W'(1);
    end else if (m > MON_W'(MONTHS)) begin
      return MON_W'(MONTHS);
    end
    return m;
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] d;
    unique case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [DAY_W-1:0] sat_day(input logic [DAY_W-1:0] d,
                                               input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] lim;
    lim = days_in(m, leap);
    if (d == '0) begin
      return DAY_W'(1);
    end else if (d > lim) begin
      return lim;
    end
    return d;
  endfunction

  // Days in the months before month m of the same year.
  function automatic logic [8:0] cum_days(input logic [MON_W-1:0] m, input logic leap);
    logic [8:0] c;
    unique case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      default: c = 9'd334;
    endcase
    if (leap && m > 4'd2) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

  // Restoring division of a day number into 400, 100, 4 and 1 year cycles.
  // The 100 and 1 year stages keep two quotient bits, which caps them at three.
  function automatic div_step_t div_step(input logic [STEP_W-1:0] idx);
    div_step_t s;
    unique case (idx)
      4'd0:    s = '{NUM_W'(DAYS_400Y * 16), YEAR_W'(400 * 16)};
      4'd1:    s = '{NUM_W'(DAYS_400Y * 8),  YEAR_W'(400 * 8)};
      4'd2:    s = '{NUM_W'(DAYS_400Y * 4),  YEAR_W'(400 * 4)};
      4'd3:    s = '{NUM_W'(DAYS_400Y * 2),  YEAR_W'(400 * 2)};
      4'd4:    s = '{NUM_W'(DAYS_400Y),      YEAR_W'(400)};
      4'd5:    s = '{NUM_W'(DAYS_100Y * 2),  YEAR_W'(100 * 2)};
      4'd6:    s = '{NUM_W'(DAYS_100Y),      YEAR_W'(100)};
      4'd7:    s = '{NUM_W'(DAYS_4Y * 16),   YEAR_W'(4 * 16)};
      4'd8:    s = '{NUM_W'(DAYS_4Y * 8),    YEAR_W'(4 * 8)};
      4'd9:    s = '{NUM_W'(DAYS_4Y * 4),    YEAR_W'(4 * 4)};
      4'd10:   s = '{NUM_W'(DAYS_4Y * 2),    YEAR_W'(4 * 2)};
      4'd11:   s = '{NUM_W'(DAYS_4Y),        YEAR_W'(4)};
      4'd12:   s = '{NUM_W'(DAYS_1Y * 2),    YEAR_W'(2)};
      4'd13:   s = '{NUM_W'(DAYS_1Y),        YEAR_W'(1)};
      default: s = '{'0, '0};
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/cdod_ctrl.sv =====
module cdod_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  cdod_pkg::stat_t stat,
  output cdod_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);
  import cdod_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_LEAP;
        end
      end
      ST_LEAP:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_ADD;
      ST_ADD:   state_next = ST_NUM;
      ST_NUM:   state_next = ST_CLAMP;
      ST_CLAMP: begin
        step_next  = '0;
        state_next = stat.mode ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_RLEAP;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_RLEAP: state_next = ST_WALK;
      ST_WALK: begin
        if (stat.walk_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.step  = step;
    cmd.load  = (state == ST_IDLE) && start;
    cmd.leap  = (state == ST_LEAP);
    cmd.mul   = (state == ST_MUL);
    cmd.add   = (state == ST_ADD);
    cmd.num   = (state == ST_NUM);
    cmd.clamp = (state == ST_CLAMP);
    cmd.div   = (state == ST_DIV);
    cmd.rleap = (state == ST_RLEAP);
    cmd.walk  = (state == ST_WALK);
    busy      = (state != ST_IDLE);
    done      = (state == ST_DONE);
  end

endmodule

// ===== rtl/core/cdod_dp.sv =====
module cdod_dp (
  input  logic                                clk,
  input  cdod_pkg::cmd_t                      cmd,
  output cdod_pkg::stat_t                     stat,
  input  logic                                func,
  input  logic [cdod_pkg::YEAR_W-1:0]         a_year,
  input  logic [cdod_pkg::MON_W-1:0]          a_month,
  input  logic [cdod_pkg::DAY_W-1:0]          a_day,
  input  logic [cdod_pkg::YEAR_W-1:0]         b_year,
  input  logic [cdod_pkg::MON_W-1:0]          b_month,
  input  logic [cdod_pkg::DAY_W-1:0]          b_day,
  input  logic signed [cdod_pkg::OFS_W-1:0]   day_offset,
  output logic [cdod_pkg::YEAR_W-1:0]         res_year,
  output logic [cdod_pkg::MON_W-1:0]          res_month,
  output logic [cdod_pkg::DAY_W-1:0]          res_day,
  output logic signed [cdod_pkg::OFS_W-1:0]   day_difference,
  output logic                                a_later,
  output logic                                a_equal,
  output logic                                out_of_range
);
  import cdod_pkg::*;

  logic                    mode;
  logic [YEAR_W-1:0]       ay;
  logic [MON_W-1:0]        am;
  logic [DAY_W-1:0]        ad;
  logic [YEAR_W-1:0]       by;
  logic [MON_W-1:0]        bm;
  logic [DAY_W-1:0]        bd;
  logic signed [OFS_W-1:0] off;
  logic                    leap_a;
  logic                    leap_b;
  logic [NUM_W-1:0]        prod_a;
  logic [NUM_W-1:0]        prod_b;
  logic [6:0]              q100_a;
  logic [6:0]              q100_b;
  logic [NUM_W-1:0]        base_a;
  logic [NUM_W-1:0]        base_b;
  logic [NUM_W-1:0]        na;
  logic [NUM_W-1:0]        nb;
  logic signed [OFS_W-1:0] diff;
  logic                    ovf;
  logic [NUM_W-1:0]        rem;
  logic [YEAR_W-1:0]       yacc;
  logic [MON_W-1:0]        mon;

  logic [YEAR_W-1:0]       pa;
  logic [YEAR_W-1:0]       pb;
  logic [NUM_W:0]          m365_a;
  logic [NUM_W:0]          m365_b;
  logic [26:0]             m100_a;
  logic [26:0]             m100_b;
  logic [YEAR_W-1:0]       leap_src;
  logic signed [OFS_W:0]   sumn;
  logic [NUM_W-1:0]        clamped;
  logic                    sum_low;
  logic                    sum_high;
  div_step_t               st;
  logic [DAY_W-1:0]        len;
  logic                    go;

  assign pa       = ay - YEAR_W'(1);
  assign pb       = by - YEAR_W'(1);
  assign m365_a   = (NUM_W+1)'(pa) * (NUM_W+1)'(DAYS_1Y);
  assign m365_b   = (NUM_W+1)'(pb) * (NUM_W+1)'(DAYS_1Y);
  assign m100_a   = 27'(pa) * 27'(RECIP100);
  assign m100_b   = 27'(pb) * 27'(RECIP100);
  assign leap_src = cmd.rleap ? yacc : ay;

  assign sumn     = $signed({2'b00, na}) + $signed({off[OFS_W-1], off});
  assign sum_low  = sumn[OFS_W];
  assign sum_high = !sum_low && (sumn[OFS_W-1:0] > OFS_W'(LAST_DAYNUM));
  assign clamped  = sum_low ? '0 : (sum_high ? NUM_W'(LAST_DAYNUM) : sumn[NUM_W-1:0]);

  assign st  = div_step(cmd.step);
  assign len = days_in(mon, leap_a);
  assign go  = (rem >= NUM_W'(len)) && (mon != MON_W'(MONTHS));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= func;
      ay   <= sat_year(a_year);
      am   <= sat_month(a_month);
      ad   <= a_day;
      by   <= sat_year(b_year);
      bm   <= sat_month(b_month);
      bd   <= b_day;
      off  <= day_offset;
    end
    if (cmd.leap || cmd.rleap) begin
      leap_a <= is_leap(leap_src);
    end
    if (cmd.leap) begin
      leap_b <= is_leap(by);
    end
    if (cmd.mul) begin
      ad     <= sat_day(ad, am, leap_a);
      bd     <= sat_day(bd, bm, leap_b);
      prod_a <= m365_a[NUM_W-1:0];
      prod_b <= m365_b[NUM_W-1:0];
      q100_a <= m100_a[RECIP100_SH+6:RECIP100_SH];
      q100_b <= m100_b[RECIP100_SH+6:RECIP100_SH];
    end
    if (cmd.add) begin
      base_a <= prod_a + NUM_W'(pa[YEAR_W-1:2]) - NUM_W'(q100_a) + NUM_W'(q100_a[6:2]);
      base_b <= prod_b + NUM_W'(pb[YEAR_W-1:2]) - NUM_W'(q100_b) + NUM_W'(q100_b[6:2]);
    end
    if (cmd.num) begin
      na <= base_a + NUM_W'(cum_days(am, leap_a)) + NUM_W'(ad) - NUM_W'(1);
      nb <= base_b + NUM_W'(cum_days(bm, leap_b)) + NUM_W'(bd) - NUM_W'(1);
    end
    if (cmd.clamp) begin
      diff <= mode ? ($signed({1'b0, na}) - $signed({1'b0, nb})) : '0;
      ovf  <= !mode && (sum_low || sum_high);
      rem  <= clamped;
      yacc <= YEAR_W'(1);
      mon  <= MON_W'(1);
    end
    if (cmd.div && (rem >= st.divisor)) begin
      rem  <= rem - st.divisor;
      yacc <= yacc + st.weight;
    end
    if (cmd.walk && go) begin
      rem <= rem - NUM_W'(len);
      mon <= mon + MON_W'(1);
    end
  end

  assign stat.mode      = mode;
  assign stat.walk_done = !go;

  assign res_year       = mode ? ay : yacc;
  assign res_month      = mode ? am : mon;
  assign res_day        = mode ? ad : (rem[DAY_W-1:0] + DAY_W'(1));
  assign day_difference = diff;
  assign a_later        = (na > nb);
  assign a_equal        = (na == nb);
  assign out_of_range   = ovf;

endmodule

// ===== rtl/core/calendar_date_offset_difference.sv =====
// Gregorian date unit. A word is taken at a rising edge where start is high and busy is low;
// busy then stays high until the result has been shown. The result appears on the result ports
// for exactly one cycle, marked by done, and the receiver has no way to hold it off, so it must
// capture the word in that cycle. In difference mode (func = 1) done follows the leap,
// multiply, add, number and clamp states. In offset mode (func = 0) the clamp state is
// followed by the 14 restoring subtract steps that split the day number into 400, 100, 4
// and 1 year cycles, a leap step for the result year and the month walk, one month per cycle.
// A new word may be taken in the cycle after done.
module calendar_date_offset_difference (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  output logic                                done,
  input  logic                                func,
  input  logic [cdod_pkg::YEAR_W-1:0]         a_year,
  input  logic [cdod_pkg::MON_W-1:0]          a_month,
  input  logic [cdod_pkg::DAY_W-1:0]          a_day,
  input  logic [cdod_pkg::YEAR_W-1:0]         b_year,
  input  logic [cdod_pkg::MON_W-1:0]          b_month,
  input  logic [cdod_pkg::DAY_W-1:0]          b_day,
  input  logic signed [cdod_pkg::OFS_W-1:0]   day_offset,
  output logic [cdod_pkg::YEAR_W-1:0]         res_year,
  output logic [cdod_pkg::MON_W-1:0]          res_month,
  output logic [cdod_pkg::DAY_W-1:0]          res_day,
  output logic signed [cdod_pkg::OFS_W-1:0]   day_difference,
  output logic                                a_later,
  output logic                                a_equal,
  output logic                                out_of_range
);
  import cdod_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cdod_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  cdod_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .stat           (stat),
    .func           (func),
    .a_year         (a_year),
    .a_month        (a_month),
    .a_day          (a_day),
    .b_year         (b_year),
    .b_month        (b_month),
    .b_day          (b_day),
    .day_offset     (day_offset),
    .res_year       (res_year),
    .res_month      (res_month),
    .res_day        (res_day),
    .day_difference (day_difference),
    .a_later        (a_later),
    .a_equal        (a_equal),
    .out_of_range   (out_of_range)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown while idle");

  a_clamp_date: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |->
      ((res_year == 14'd1 && res_month == 4'd1 && res_day == 5'd1) ||
       (res_year == 14'd9999 && res_month == 4'd12 && res_day == 5'd31)))
    else $error("clamped result is not a calendar end date");

  a_equal_later: assert property (@(posedge clk) disable iff (rst)
    done |-> !(a_equal && a_later))
    else $error("dates reported both equal and later");
`endif

endmodule
